// File: design/hold_timer_fan_ramp_control_top_defines.svh
// Assertion macros for the hold timer / fan ramp block.
// Used by hold_timer_fan_ramp_control_top; expects clock and reset in scope.
`ifndef HOLD_TIMER_FAN_RAMP_CONTROL_TOP_DEFINES_SVH
`define HOLD_TIMER_FAN_RAMP_CONTROL_TOP_DEFINES_SVH

// same-cycle implication
`define HTFR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HTFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/htfr_pkg.sv
// Shared types and constants for the hold timer / fan ramp block.
// No dependencies.
`timescale 1ns / 1ps

package htfr_pkg;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned MS_W   = 16;
   localparam int unsigned DUTY_W = 7;
   localparam int unsigned IDX_W  = 3;

   localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

   localparam logic [IDX_W-1:0] REG_ARM_DELAY  = 3'd0;
   localparam logic [IDX_W-1:0] REG_HOLD       = 3'd1;
   localparam logic [IDX_W-1:0] REG_ON_DUTY    = 3'd2;
   localparam logic [IDX_W-1:0] REG_SOFT_START = 3'd3;
   localparam logic [IDX_W-1:0] REG_SOFT_STOP  = 3'd4;
   localparam logic [IDX_W-1:0] REG_POLARITY   = 3'd5;

   localparam int unsigned RST_ARM_DELAY  = 1000;
   localparam int unsigned RST_HOLD       = 2000;
   localparam int unsigned RST_ON_DUTY    = 80;
   localparam int unsigned RST_SOFT_START = 2000;
   localparam int unsigned RST_SOFT_STOP  = 1000;
   localparam int unsigned RST_UP_INT     = RST_SOFT_START / RST_ON_DUTY;
   localparam int unsigned RST_DN_INT     = RST_SOFT_STOP / RST_ON_DUTY;

   // one quotient bit per step, counter holds 0..MS_W
   localparam int unsigned DIV_STEPS = MS_W;
   localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

   typedef struct packed {
      logic [TIME_W-1:0] now_time;
      logic              is_moving;
   } req_type;

   typedef struct packed {
      logic              brush_on;
      logic              brush_pin;
      logic [DUTY_W-1:0] fan_duty;
      logic              duty_changed;
      logic              is_armed;
   } rsp_type;

   typedef struct packed {
      logic [MS_W-1:0]   arm_delay;
      logic [MS_W-1:0]   hold;
      logic [DUTY_W-1:0] on_duty;
      logic              active_high;
      logic [MS_W-1:0]   up_int;
      logic [MS_W-1:0]   dn_int;
      logic              busy;
   } cfg_type;

   function automatic logic [DUTY_W-1:0] eff_duty(input logic [DUTY_W-1:0] d);
      return (d > DUTY_MAX) ? DUTY_MAX : d;
   endfunction

endpackage

// File: design/htfr_cfg.sv
// Configuration registers and the serial divider for the ramp step intervals.
// Depends on htfr_pkg.
`timescale 1ns / 1ps

module htfr_cfg (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [htfr_pkg::IDX_W-1:0] csr_index,
   input  logic [htfr_pkg::MS_W-1:0]  csr_wdata,
   output htfr_pkg::cfg_type          cfg
);
   import htfr_pkg::*;

   logic [MS_W-1:0]   arm_delay_ff, hold_ff, soft_start_ff, soft_stop_ff;
   logic [DUTY_W-1:0] on_duty_ff;
   logic              active_high_ff;
   logic              pend_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MS_W-1:0]   uq_ff, uq_in, dq_ff, dq_in;
   logic [DUTY_W-1:0] ur_ff, ur_in, dr_ff, dr_in;
   logic [DUTY_W-1:0] span_ff;
   logic [MS_W-1:0]   up_int_ff, up_int_in, dn_int_ff, dn_int_in;
   logic [DUTY_W-1:0] span_calc;
   logic [DUTY_W:0]   u_sh, d_sh, u_sub, d_sub;

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_delay_ff   <= MS_W'(RST_ARM_DELAY);
         hold_ff        <= MS_W'(RST_HOLD);
         on_duty_ff     <= DUTY_W'(RST_ON_DUTY);
         soft_start_ff  <= MS_W'(RST_SOFT_START);
         soft_stop_ff   <= MS_W'(RST_SOFT_STOP);
         active_high_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            REG_ARM_DELAY:  arm_delay_ff   <= csr_wdata;
            REG_HOLD:       hold_ff        <= csr_wdata;
            REG_ON_DUTY:    on_duty_ff     <= csr_wdata[DUTY_W-1:0];
            REG_SOFT_START: soft_start_ff  <= csr_wdata;
            REG_SOFT_STOP:  soft_stop_ff   <= csr_wdata;
            REG_POLARITY:   active_high_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign span_calc = (eff_duty(on_duty_ff) == '0) ? DUTY_W'(1) : eff_duty(on_duty_ff);

   // restoring division, both dividends share one divisor
   always_comb begin
      u_sh      = {ur_ff, uq_ff[MS_W-1]};
      d_sh      = {dr_ff, dq_ff[MS_W-1]};
      u_sub     = u_sh - {1'b0, span_ff};
      d_sub     = d_sh - {1'b0, span_ff};
      cnt_in    = cnt_ff;
      uq_in     = uq_ff;
      dq_in     = dq_ff;
      ur_in     = ur_ff;
      dr_in     = dr_ff;
      up_int_in = up_int_ff;
      dn_int_in = dn_int_ff;
      if (pend_ff) begin
         cnt_in = CNT_W'(DIV_STEPS);
         uq_in  = soft_start_ff;
         dq_in  = soft_stop_ff;
         ur_in  = '0;
         dr_in  = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (u_sh >= {1'b0, span_ff}) begin
            ur_in = u_sub[DUTY_W-1:0];
            uq_in = {uq_ff[MS_W-2:0], 1'b1};
         end else begin
            ur_in = u_sh[DUTY_W-1:0];
            uq_in = {uq_ff[MS_W-2:0], 1'b0};
         end
         if (d_sh >= {1'b0, span_ff}) begin
            dr_in = d_sub[DUTY_W-1:0];
            dq_in = {dq_ff[MS_W-2:0], 1'b1};
         end else begin
            dr_in = d_sh[DUTY_W-1:0];
            dq_in = {dq_ff[MS_W-2:0], 1'b0};
         end
         if (cnt_ff == CNT_W'(1)) begin
            up_int_in = (uq_in == '0) ? MS_W'(1) : uq_in;
            dn_int_in = (dq_in == '0) ? MS_W'(1) : dq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= 1'b0;
         cnt_ff    <= '0;
         up_int_ff <= MS_W'(RST_UP_INT);
         dn_int_ff <= MS_W'(RST_DN_INT);
      end else begin
         pend_ff   <= csr_we;
         cnt_ff    <= csr_we ? '0 : cnt_in;
         up_int_ff <= up_int_in;
         dn_int_ff <= dn_int_in;
      end
   end

   always_ff @(posedge clock) begin
      uq_ff   <= uq_in;
      dq_ff   <= dq_in;
      ur_ff   <= ur_in;
      dr_ff   <= dr_in;
      if (pend_ff) begin
         span_ff <= span_calc;
      end
   end

   assign cfg.arm_delay   = arm_delay_ff;
   assign cfg.hold        = hold_ff;
   assign cfg.on_duty     = on_duty_ff;
   assign cfg.active_high = active_high_ff;
   assign cfg.up_int      = up_int_ff;
   assign cfg.dn_int      = dn_int_ff;
   assign cfg.busy        = csr_we | pend_ff | (cnt_ff != '0);

endmodule

// File: design/htfr_core.sv
// Input register, timer state, duty ramp step and result register.
// Depends on htfr_pkg.
`timescale 1ns / 1ps

module htfr_core (
   input  logic              clock,
   input  logic              reset,
   input  htfr_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  htfr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output htfr_pkg::rsp_type rsp_data
);
   import htfr_pkg::*;

   logic              s1_valid_ff;
   req_type           s1_data_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              armed_ff, armed_in;
   logic              clean_ff, clean_in;
   logic [TIME_W-1:0] last_ff, last_in;
   logic [TIME_W-1:0] ramp_ff, ramp_in;
   logic [DUTY_W-1:0] duty_ff, duty_in;
   logic [DUTY_W-1:0] goal_ff, goal_in;

   logic              adv;
   logic              active;
   logic              want;
   logic              rising;
   logic              changed;
   logic [TIME_W-1:0] now;
   logic [TIME_W-1:0] move_diff;
   logic [TIME_W-1:0] ramp_diff;
   logic [MS_W-1:0]   interval;

   assign adv       = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~cfg.busy & (~s1_valid_ff | adv);
   assign now       = s1_data_ff.now_time;

   always_comb begin
      active    = armed_ff | (now >= TIME_W'(cfg.arm_delay));
      // on the arming transfer the last move sits exactly hold_ms back
      move_diff = armed_ff ? (now - last_ff) : TIME_W'(cfg.hold);
      ramp_diff = armed_ff ? (now - ramp_ff) : '0;
      want      = s1_data_ff.is_moving | (move_diff < TIME_W'(cfg.hold));

      armed_in  = armed_ff;
      clean_in  = clean_ff;
      last_in   = last_ff;
      ramp_in   = ramp_ff;
      duty_in   = duty_ff;
      goal_in   = goal_ff;
      changed   = 1'b0;
      rising    = 1'b0;
      interval  = cfg.dn_int;

      if (active) begin
         armed_in = 1'b1;
         if (!armed_ff) begin
            last_in = now - TIME_W'(cfg.hold);
            ramp_in = now;
         end
         if (s1_data_ff.is_moving) begin
            last_in = now;
         end
         if (want != clean_ff) begin
            clean_in = want;
            goal_in  = want ? eff_duty(cfg.on_duty) : '0;
         end
         if (duty_ff != goal_in) begin
            rising   = duty_ff < goal_in;
            interval = rising ? cfg.up_int : cfg.dn_int;
            if (ramp_diff >= TIME_W'(interval)) begin
               ramp_in = now;
               duty_in = rising ? duty_ff + DUTY_W'(1) : duty_ff - DUTY_W'(1);
               changed = 1'b1;
            end
         end
      end

      rsp_data_in.brush_on     = clean_in;
      rsp_data_in.brush_pin    = cfg.active_high ? clean_in : ~clean_in;
      rsp_data_in.fan_duty     = duty_in;
      rsp_data_in.duty_changed = changed;
      rsp_data_in.is_armed     = armed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         armed_ff     <= 1'b0;
         clean_ff     <= 1'b0;
         last_ff      <= '0;
         ramp_ff      <= '0;
         duty_ff      <= '0;
         goal_ff      <= '0;
      end else begin
         if (req_valid && req_ready) begin
            s1_valid_ff <= 1'b1;
         end else if (adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (adv) begin
            rsp_valid_ff <= 1'b1;
            armed_ff     <= armed_in;
            clean_ff     <= clean_in;
            last_ff      <= last_in;
            ramp_ff      <= ramp_in;
            duty_ff      <= duty_in;
            goal_ff      <= goal_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: design/hold_timer_fan_ramp_control_top.sv
// Top level of the hold timer / fan ramp block: configuration and timer core.
// Depends on htfr_pkg, htfr_cfg, htfr_core and the defines header.
`timescale 1ns / 1ps
`include "hold_timer_fan_ramp_control_top_defines.svh"

// Brush off-delay timer with a soft-start / soft-stop fan duty ramp.
// req channel: valid/ready, one transfer per timer tick carrying now_time (ms)
//   and is_moving. rsp channel: valid/ready, one result per request with the
//   brush state, brush pin level, fan duty, a duty-step flag and the armed flag.
// csr port: write enable, register index and 16-bit data, no wait state.
//   Indexes 0..5 are arm delay, hold, on duty, soft start, soft stop and
//   polarity; other indexes are ignored.
// The request path is the input register, then the result register. Throughput: one
//   transfer per cycle while rsp is not stalled and no interval rebuild runs,
//   set by the combinational timer update between the two registers.
// After each csr write the ramp step intervals are rebuilt by a serial
//   divider, one quotient bit a cycle; req_ready stays low until it is done.
// Reset clears the timer state (not armed, brush off, duty 0) and loads the
//   default registers with their intervals ready; no requests are blocked.
// A stalled rsp holds its result; the input register keeps accepting until
//   both stages are full, then req_ready drops.
module hold_timer_fan_ramp_control_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  htfr_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output htfr_pkg::rsp_type          rsp_data,
   input  logic                       csr_we,
   input  logic [htfr_pkg::IDX_W-1:0] csr_index,
   input  logic [htfr_pkg::MS_W-1:0]  csr_wdata
);
   import htfr_pkg::*;

   cfg_type cfg;
   logic    step_seen;

   htfr_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   htfr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign step_seen = rsp_valid & rsp_data.duty_changed;

   `HTFR_ASSERT_NOW(a_busy_blocks_req, cfg.busy, !req_ready, "req taken while intervals rebuild")
   `HTFR_ASSERT_NEXT(a_we_blocks_req, csr_we, !req_ready, "req ready right after csr write")
   `HTFR_ASSERT_NOW(a_step_needs_arm, step_seen, rsp_data.is_armed, "duty step before arming")
   `HTFR_ASSERT_NOW(a_duty_range, rsp_valid, rsp_data.fan_duty <= DUTY_MAX, "duty above max")

endmodule
